// ===== rtl/orsb_pkg.sv =====
// shared constants, codes and types of the overwriting slot ring buffer
package orsb_pkg;

  // default sizes
  localparam int unsigned SLOTS_DEF      = 16;
  localparam int unsigned SLOT_BYTES_DEF = 64;

  // field widths
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned IDX_W      = 64;
  localparam int unsigned OFF_W      = 6;
  localparam int unsigned STAT_W     = 3;
  localparam int unsigned CNT_LOG2_W = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 7;

  // envelope header
  localparam int unsigned ENV_HDR_BYTES = 16;
  localparam logic [BYTE_W-1:0] MAGIC_0 = 8'h52;
  localparam logic [BYTE_W-1:0] MAGIC_1 = 8'h43;
  localparam logic [BYTE_W-1:0] MAGIC_2 = 8'h54;
  localparam logic [BYTE_W-1:0] MAGIC_3 = 8'h31;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] SLOT_BYTES_USED_RST = 7'd64;
  localparam logic [CNT_LOG2_W-1:0] SLOT_COUNT_LOG2_RST = 3'd4;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PLAIN    = 2'd0,
    FUNC_ENVELOPE = 2'd1,
    FUNC_READ     = 2'd2,
    FUNC_QUERY    = 2'd3
  } orsb_func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_TOO_LONG   = 3'd1,
    STAT_MISMATCH   = 3'd2,
    STAT_BAD_INDEX  = 3'd3,
    STAT_BAD_OFFSET = 3'd4
  } orsb_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOT_BYTES_USED = 1'b0,
    CFG_SLOT_COUNT_LOG2 = 1'b1
  } orsb_cfg_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2,
    ST_COPY  = 2'd3
  } orsb_state_e;

  // commit request from the control to the copy engine
  typedef struct packed {
    logic             start;
    logic             envelope;
    logic [LEN_W-1:0] length;
    logic [IDX_W-1:0] index;
  } orsb_copy_cmd_t;

endpackage

// ===== rtl/orsb_if.sv =====
// input item and result channels with valid/ready handshake
interface orsb_in_if;
  import orsb_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [BYTE_W-1:0] data_byte;
  logic              last;
  logic [LEN_W-1:0]  msg_len;
  logic [IDX_W-1:0]  read_index;
  logic [OFF_W-1:0]  read_offset;

  modport source (
    output valid, func, data_byte, last, msg_len, read_index, read_offset,
    input  ready
  );
  modport sink (
    input  valid, func, data_byte, last, msg_len, read_index, read_offset,
    output ready
  );
endinterface

interface orsb_out_if;
  import orsb_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [BYTE_W-1:0] read_byte;
  logic              committed;
  logic [IDX_W-1:0]  assigned_index;
  logic [IDX_W-1:0]  latest_index;
  logic [IDX_W-1:0]  oldest_index;
  logic [IDX_W-1:0]  write_count;
  logic              empty_res;

  modport source (
    output valid, status, read_byte, committed, assigned_index, latest_index,
           oldest_index, write_count, empty_res,
    input  ready
  );
  modport sink (
    input  valid, status, read_byte, committed, assigned_index, latest_index,
           oldest_index, write_count, empty_res,
    output ready
  );
endinterface

// ===== rtl/orsb_ram.sv =====
// generic single-write, single-read ram with registered read data
module orsb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/orsb_copy.sv =====
// commit engine: streams staging bytes and envelope header into one ring slot
module orsb_copy #(
  parameter int unsigned SLOTS      = orsb_pkg::SLOTS_DEF,
  parameter int unsigned SLOT_BYTES = orsb_pkg::SLOT_BYTES_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  orsb_pkg::orsb_copy_cmd_t              cmd_i,
  input  logic [$clog2(SLOTS*SLOT_BYTES)-1:0]   base_i,
  input  logic [$clog2(SLOT_BYTES+1)-1:0]       end_i,
  output logic                                  busy_o,
  output logic                                  stg_re_o,
  output logic [$clog2(SLOT_BYTES)-1:0]         stg_raddr_o,
  input  logic [orsb_pkg::BYTE_W-1:0]           stg_rdata_i,
  output logic                                  slot_we_o,
  output logic [$clog2(SLOTS*SLOT_BYTES)-1:0]   slot_waddr_o,
  output logic [orsb_pkg::BYTE_W-1:0]           slot_wdata_o
);
  import orsb_pkg::*;

  localparam int unsigned AW = $clog2(SLOTS*SLOT_BYTES);
  localparam int unsigned PW = $clog2(SLOT_BYTES);
  localparam int unsigned SW = $clog2(SLOT_BYTES+1);
  localparam int unsigned CW = (PW > LEN_W) ? PW : LEN_W;

  logic             act_q;
  logic             wr_vld_q;
  logic [PW-1:0]    pos_q;
  logic [PW-1:0]    wr_pos_q;
  logic [SW-1:0]    end_q;
  logic [AW-1:0]    base_q;
  logic             env_q;
  logic [LEN_W-1:0] len_q;
  logic [IDX_W-1:0] idx_q;
  logic             last_pos;

  // envelope header byte at a header position
  function automatic logic [BYTE_W-1:0] hdr_byte(input logic [3:0] p,
                                                 input logic [LEN_W-1:0] len,
                                                 input logic [IDX_W-1:0] index);
    logic [BYTE_W-1:0] b;
    b = '0;
    if (p[3]) begin
      b = index[8*p[2:0] +: 8];
    end else if (p[2]) begin
      b = (p[1:0] == 2'd0) ? BYTE_W'(len) : '0;
    end else begin
      unique case (p[1:0])
        2'd0:    b = MAGIC_0;
        2'd1:    b = MAGIC_1;
        2'd2:    b = MAGIC_2;
        default: b = MAGIC_3;
      endcase
    end
    return b;
  endfunction

  assign last_pos = (SW'(pos_q) + SW'(1)) == end_q;

  // issue and write-back valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= 1'b0;
      wr_vld_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        act_q <= 1'b1;
      end else if (act_q && last_pos) begin
        act_q <= 1'b0;
      end
      wr_vld_q <= act_q;
    end
  end

  // job and position registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pos_q  <= '0;
      end_q  <= end_i;
      base_q <= base_i;
      env_q  <= cmd_i.envelope;
      len_q  <= cmd_i.length;
      idx_q  <= cmd_i.index;
    end else if (act_q) begin
      pos_q <= pos_q + PW'(1);
    end
    wr_pos_q <= pos_q;
  end

  // staging read, payload sits behind the header for envelopes
  assign stg_re_o    = act_q;
  assign stg_raddr_o = env_q ? (pos_q - PW'(ENV_HDR_BYTES)) : pos_q;

  // slot write in the cycle after the staging read
  always_comb begin
    slot_wdata_o = stg_rdata_i;
    if (env_q) begin
      if (wr_pos_q < PW'(ENV_HDR_BYTES)) begin
        slot_wdata_o = hdr_byte(wr_pos_q[3:0], len_q, idx_q);
      end
    end else if (CW'(wr_pos_q) >= CW'(len_q)) begin
      slot_wdata_o = '0;
    end
  end

  assign slot_we_o    = wr_vld_q;
  assign slot_waddr_o = base_q + AW'(wr_pos_q);
  assign busy_o       = act_q | wr_vld_q;

endmodule

// ===== rtl/overwrite_ring_slot_buffer.sv =====
// overwriting slot ring buffer: control, message tracking, memories and result register
//
//  channel   | dir | transfer moves
//  ----------+-----+------------------------------------------------------
//  in_i      | in  | func, data_byte, last, msg_len, read_index, read_offset
//  out_o     | out | status, read_byte, committed, indexes, count, empty
//  cfg_*_i   | in  | register index and data, taken when cfg_we_i is high
//
//  every item is accepted (slot ram read issued), then executed
//  a committing item then copies N bytes into the slot, N = bytes written
//  into the slot (used slot size, or header plus payload for envelopes)
//  after reset the slot ram is zeroed, and no items are taken while it is cleared
//  an item is taken only when the result register is free or being drained
module overwrite_ring_slot_buffer #(
  parameter int unsigned SLOTS      = orsb_pkg::SLOTS_DEF,
  parameter int unsigned SLOT_BYTES = orsb_pkg::SLOT_BYTES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  orsb_in_if.sink                             in_i,
  orsb_out_if.source                          out_o,
  input  logic                                cfg_we_i,
  input  logic [orsb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [orsb_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import orsb_pkg::*;

  localparam int unsigned DEPTH     = SLOTS * SLOT_BYTES;
  localparam int unsigned AW        = $clog2(DEPTH);
  localparam int unsigned PW        = $clog2(SLOT_BYTES);
  localparam int unsigned SW        = $clog2(SLOT_BYTES+1);
  localparam int unsigned SLW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned LOG2_MAX  = $clog2(SLOTS+1) - 1;
  localparam int unsigned NSLOT_W   = 8;

  // fsm
  orsb_state_e state_q, state_d;

  // configuration
  logic [CFG_DATA_W-1:0] sbu_q;
  logic [CNT_LOG2_W-1:0] cnt_log2_q;

  // message tracking
  logic [IDX_W-1:0] cc_q;
  logic [LEN_W-1:0] bt_q;
  logic [LEN_W-1:0] dl_q;
  logic             in_msg_q;
  logic             drop_q;
  logic             env_q;

  // accepted item
  orsb_func_e       it_func_q;
  logic [BYTE_W-1:0] it_data_q;
  logic             it_last_q;
  logic [LEN_W-1:0] it_mlen_q;
  logic [IDX_W-1:0] it_ridx_q;
  logic [OFF_W-1:0] it_roff_q;

  // result register
  logic               out_valid_q;
  orsb_status_e       out_status_q;
  logic [BYTE_W-1:0]  out_rbyte_q;
  logic               out_committed_q;
  logic [IDX_W-1:0]   out_assigned_q;
  logic [IDX_W-1:0]   out_count_q;
  logic [NSLOT_W-1:0] out_slots_q;

  // clearing sweep
  logic [AW-1:0] clr_q;

  // derived configuration
  logic [SW-1:0]         s_eff;
  logic [CNT_LOG2_W-1:0] n_eff;
  logic [SLW-1:0]        slot_mask;
  logic [NSLOT_W-1:0]    slots_eff;

  // handshake
  logic in_ready;
  logic in_acc;
  logic out_take;

  // execute stage
  logic             is_exec;
  logic             is_write;
  logic             count_it;
  logic [LEN_W-1:0] dl_x;
  logic             env_x;
  logic             drop_x;
  logic [LEN_W-1:0] bt0;
  logic [LEN_W-1:0] bt1;
  logic             stg_we;
  orsb_status_e     wstat;
  orsb_status_e     rstat;
  orsb_status_e     res_stat;
  logic             do_commit;
  logic [IDX_W:0]   win_diff;
  logic [SW-1:0]    copy_end;
  logic [SLW-1:0]   cm_slot;
  logic [AW-1:0]    cm_base;

  // read address
  logic [SLW-1:0] rd_slot;
  logic [AW-1:0]  rd_addr;
  logic           rd_re;

  // memories and copy engine
  orsb_copy_cmd_t    copy_cmd;
  logic              copy_busy;
  logic              stg_re;
  logic [PW-1:0]     stg_raddr;
  logic [BYTE_W-1:0] stg_rdata;
  logic              cp_we;
  logic [AW-1:0]     cp_waddr;
  logic [BYTE_W-1:0] cp_wdata;
  logic              slot_we;
  logic [AW-1:0]     slot_waddr;
  logic [BYTE_W-1:0] slot_wdata;
  logic [BYTE_W-1:0] slot_rdata;

  // effective slot size and slot count
  always_comb begin
    if (sbu_q == '0) begin
      s_eff = SW'(1);
    end else if (int'(sbu_q) > int'(SLOT_BYTES)) begin
      s_eff = SW'(SLOT_BYTES);
    end else begin
      s_eff = SW'(sbu_q);
    end
    n_eff     = (int'(cnt_log2_q) > int'(LOG2_MAX)) ? CNT_LOG2_W'(LOG2_MAX) : cnt_log2_q;
    slot_mask = SLW'((32'd1 << n_eff) - 32'd1);
    slots_eff = NSLOT_W'(1) << n_eff;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbu_q      <= SLOT_BYTES_USED_RST;
      cnt_log2_q <= SLOT_COUNT_LOG2_RST;
    end else if (cfg_we_i) begin
      unique case (orsb_cfg_e'(cfg_idx_i))
        CFG_SLOT_BYTES_USED: sbu_q      <= cfg_wdata_i;
        CFG_SLOT_COUNT_LOG2: cnt_log2_q <= cfg_wdata_i[CNT_LOG2_W-1:0];
      endcase
    end
  end

  // handshake
  assign out_take = out_valid_q && out_o.ready;
  assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign in_acc   = in_i.valid && in_ready;

  // slot ram read is issued with the accept
  assign rd_slot = in_i.read_index[SLW-1:0] & slot_mask;
  assign rd_addr = AW'(rd_slot) * AW'(SLOT_BYTES) + AW'(in_i.read_offset);
  assign rd_re   = in_acc && (orsb_func_e'(in_i.func) == FUNC_READ);

  // message bookkeeping for a write item
  always_comb begin
    is_exec  = (state_q == ST_EXEC);
    is_write = (it_func_q == FUNC_PLAIN) || (it_func_q == FUNC_ENVELOPE);
    if (!in_msg_q) begin
      dl_x     = it_mlen_q;
      env_x    = (it_func_q == FUNC_ENVELOPE);
      bt0      = '0;
      count_it = (it_mlen_q != '0);
      if (env_x) begin
        drop_x = (int'(it_mlen_q) + int'(ENV_HDR_BYTES)) > int'(s_eff);
      end else begin
        drop_x = int'(it_mlen_q) > int'(s_eff);
      end
    end else begin
      dl_x     = dl_q;
      env_x    = env_q;
      bt0      = bt_q;
      count_it = 1'b1;
      drop_x   = drop_q;
    end
    stg_we = is_exec && is_write && count_it && !drop_x && (bt0 < dl_x)
             && (int'(bt0) < int'(SLOT_BYTES));
    bt1 = (count_it && (bt0 != {LEN_W{1'b1}})) ? bt0 + LEN_W'(1) : bt0;
    priority if (drop_x) begin
      wstat = STAT_TOO_LONG;
    end else if (bt1 > dl_x) begin
      wstat = STAT_MISMATCH;
    end else begin
      wstat = STAT_OK;
    end
    if (it_last_q && (wstat == STAT_OK) && (bt1 != dl_x)) begin
      wstat = STAT_MISMATCH;
    end
    do_commit = is_exec && is_write && it_last_q && (wstat == STAT_OK);
  end

  // read window check
  always_comb begin
    win_diff = {1'b0, cc_q} - {1'b0, it_ridx_q};
    priority if (int'(it_roff_q) >= int'(s_eff)) begin
      rstat = STAT_BAD_OFFSET;
    end else if (win_diff[IDX_W] || (win_diff[IDX_W-1:0] == '0)
                 || (win_diff[IDX_W-1:0] > IDX_W'(slots_eff))) begin
      rstat = STAT_BAD_INDEX;
    end else begin
      rstat = STAT_OK;
    end
  end

  // result status by function
  always_comb begin
    unique case (it_func_q)
      FUNC_PLAIN, FUNC_ENVELOPE: res_stat = wstat;
      FUNC_READ:                 res_stat = rstat;
      FUNC_QUERY:                res_stat = STAT_OK;
    endcase
  end

  // copy job: slot base and number of slot bytes to write
  always_comb begin
    cm_slot = cc_q[SLW-1:0] & slot_mask;
    cm_base = AW'(cm_slot) * AW'(SLOT_BYTES);
    if (!env_x) begin
      copy_end = s_eff;
    end else if (int'(s_eff) <= int'(ENV_HDR_BYTES)) begin
      copy_end = SW'(ENV_HDR_BYTES);
    end else if ((int'(dl_x) + int'(ENV_HDR_BYTES)) < int'(s_eff)) begin
      copy_end = SW'(int'(dl_x) + int'(ENV_HDR_BYTES));
    end else begin
      copy_end = s_eff;
    end
    copy_cmd.start    = do_commit;
    copy_cmd.envelope = env_x;
    copy_cmd.length   = dl_x;
    copy_cmd.index    = cc_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == AW'(DEPTH-1)) state_d = ST_IDLE;
      ST_IDLE:  if (in_acc) state_d = ST_EXEC;
      ST_EXEC:  state_d = do_commit ? ST_COPY : ST_IDLE;
      ST_COPY:  if (!copy_busy) state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cc_q        <= '0;
      bt_q        <= '0;
      dl_q        <= '0;
      in_msg_q    <= 1'b0;
      drop_q      <= 1'b0;
      env_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (is_exec && is_write) begin
        dl_q  <= dl_x;
        env_q <= env_x;
        if (it_last_q) begin
          in_msg_q <= 1'b0;
          drop_q   <= 1'b0;
          bt_q     <= '0;
        end else begin
          in_msg_q <= 1'b1;
          drop_q   <= drop_x;
          bt_q     <= bt1;
        end
      end
      if (do_commit) begin
        cc_q <= cc_q + IDX_W'(1);
      end
      if (is_exec) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item and result payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      it_func_q <= orsb_func_e'(in_i.func);
      it_data_q <= in_i.data_byte;
      it_last_q <= in_i.last;
      it_mlen_q <= in_i.msg_len;
      it_ridx_q <= in_i.read_index;
      it_roff_q <= in_i.read_offset;
    end
    if (is_exec) begin
      out_status_q    <= res_stat;
      out_rbyte_q     <= ((it_func_q == FUNC_READ) && (rstat == STAT_OK)) ? slot_rdata : '0;
      out_committed_q <= do_commit;
      out_assigned_q  <= do_commit ? cc_q : '0;
      out_count_q     <= do_commit ? (cc_q + IDX_W'(1)) : cc_q;
      out_slots_q     <= slots_eff;
    end
  end

  // staging slot
  orsb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SLOT_BYTES)
  ) u_stg_ram (
    .clk_i   (clk_i),
    .we_i    (stg_we),
    .waddr_i (PW'(bt0)),
    .wdata_i (it_data_q),
    .re_i    (stg_re),
    .raddr_i (stg_raddr),
    .rdata_o (stg_rdata)
  );

  // commit copy engine
  orsb_copy #(
    .SLOTS      (SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_copy (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (copy_cmd),
    .base_i       (cm_base),
    .end_i        (copy_end),
    .busy_o       (copy_busy),
    .stg_re_o     (stg_re),
    .stg_raddr_o  (stg_raddr),
    .stg_rdata_i  (stg_rdata),
    .slot_we_o    (cp_we),
    .slot_waddr_o (cp_waddr),
    .slot_wdata_o (cp_wdata)
  );

  // slot ram write port: clearing sweep or copy engine
  assign slot_we    = (state_q == ST_CLEAR) || cp_we;
  assign slot_waddr = (state_q == ST_CLEAR) ? clr_q : cp_waddr;
  assign slot_wdata = (state_q == ST_CLEAR) ? '0 : cp_wdata;

  orsb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (rd_re),
    .raddr_i (rd_addr),
    .rdata_o (slot_rdata)
  );

  // ports
  assign in_i.ready           = in_ready;
  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.read_byte      = out_rbyte_q;
  assign out_o.committed      = out_committed_q;
  assign out_o.assigned_index = out_assigned_q;
  assign out_o.write_count    = out_count_q;
  assign out_o.empty_res      = (out_count_q == '0);
  assign out_o.latest_index   = (out_count_q == '0) ? '0 : out_count_q - IDX_W'(1);
  assign out_o.oldest_index   = (out_count_q > IDX_W'(out_slots_q))
                                ? out_count_q - IDX_W'(out_slots_q) : '0;

`ifndef SYNTHESIS
  a_exec_finds_result_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |-> !out_valid_q)
    else $error("result register still full when an item executes");

  a_copy_only_in_copy_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    copy_busy |-> state_q == ST_COPY)
    else $error("copy engine busy outside the copy state");

  a_count_moves_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cc_q) |-> $past(do_commit))
    else $error("commit count changed without a commit");

  a_no_accept_during_slot_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_we |-> !in_acc)
    else $error("item accepted while the slot ram is written");

  a_commit_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_commit |=> out_valid_q && out_committed_q)
    else $error("commit not reported in the result");
`endif

endmodule
